### rtl/srb_pkg.sv
// srb_pkg: shared constants and types of the sequence reorder buffer.
// No dependencies; used by srb_front, srb_queue, srb_back and the top level.
package srb_pkg;

  // Depth of the hand-over queue between front and back.
  localparam int QDepth = 2;

  // Sequence bits folded into the slot residue per front cycle.
  localparam int ChunkBits = 8;

  // Status of the hand-over queue, seen by both of its sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### rtl/sequence_reorder_buffer_core.sv
// Sequence reorder buffer: stores out-of-order words by sequence number modulo
// SLOT_COUNT and releases them in order. Depends on srb_pkg, srb_front,
// srb_queue and srb_back.
//
// Each input word lands in slot (seq_num mod SLOT_COUNT). If that slot is
// already taken the word is dropped and a single result with error and last
// flags set carries its payload and sequence number back. Otherwise the word
// is stored and the buffer then releases occupied slots in order from the next
// expected sequence number until it meets an empty slot; each released word
// gives one result, or two identical results when its repeat flag is set, and
// the last result caused by an input carries the last flag. Release follows
// slot occupancy alone, so a stale word sitting in the expected slot is
// released under its own stored sequence number. Both sides behave as queues:
// a word is taken when push is high and full is low, and a result when pop is
// high and empty is low. Flow: the front folds 8 sequence bits into the slot
// residue per cycle, then holds the word until the two-entry queue has room
// to take it, and is free for the next word while the back is still busy.
// The back checks and stores a word, then for each released word looks at
// occupancy, reads the slot RAM, whose read data is registered, and releases,
// with a second release for a repeat, and ends with a look that finds an
// empty slot; a dropped word is handled in the check alone. Every result
// waits until the output register is free. No clearing pass is needed: slot
// occupancy lives in flip-flops that reset clears at once.
module sequence_reorder_buffer_core #(
  parameter int SLOT_COUNT   = 8,
  parameter int SEQ_BITS     = 16,
  parameter int PAYLOAD_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // input queue side
  input  logic                    push,
  output logic                    full,
  input  logic [SEQ_BITS-1:0]     in_seq_num,
  input  logic [PAYLOAD_BITS-1:0] in_payload,
  input  logic                    in_repeat_flag,
  // result queue side
  output logic                    empty,
  input  logic                    pop,
  output logic [PAYLOAD_BITS-1:0] out_payload,
  output logic [SEQ_BITS-1:0]     out_seq,
  output logic                    out_error_flag,
  output logic                    out_last_flag
);

  // Queue word: sequence number, payload, repeat flag, slot index.
  localparam int QW = SEQ_BITS + PAYLOAD_BITS + 1 + $clog2(SLOT_COUNT);

  srb_pkg::q_status_t q_status;
  logic               q_push, q_pop;
  logic [QW-1:0]      q_wdata, q_rdata;

  // Front: take the word and work out its slot.
  srb_front #(
    .SLOT_COUNT   (SLOT_COUNT),
    .SEQ_BITS     (SEQ_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_seq_num     (in_seq_num),
    .in_payload     (in_payload),
    .in_repeat_flag (in_repeat_flag),
    .q_status       (q_status),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  // Hold classified words until the back is ready for them.
  srb_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .status (q_status)
  );

  // Back: store, drop on collision, release in order.
  srb_back #(
    .SLOT_COUNT   (SLOT_COUNT),
    .SEQ_BITS     (SEQ_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_status       (q_status),
    .q_rdata        (q_rdata),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .out_payload    (out_payload),
    .out_seq        (out_seq),
    .out_error_flag (out_error_flag),
    .out_last_flag  (out_last_flag)
  );

endmodule

### rtl/srb_ram.sv
// srb_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module srb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/srb_front.sv
// srb_front: accepts input words and works out their slot (seq mod slot count),
// a chunk of sequence bits per cycle. Depends on srb_pkg.
module srb_front #(
  parameter int SLOT_COUNT   = 8,
  parameter int SEQ_BITS     = 16,
  parameter int PAYLOAD_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   push,
  output logic                                   full,
  input  logic [SEQ_BITS-1:0]                    in_seq_num,
  input  logic [PAYLOAD_BITS-1:0]                in_payload,
  input  logic                                   in_repeat_flag,
  input  srb_pkg::q_status_t                     q_status,
  output logic                                   q_push,
  output logic [SEQ_BITS+PAYLOAD_BITS+$clog2(SLOT_COUNT):0] q_wdata
);

  localparam int SlotW = $clog2(SLOT_COUNT);
  localparam int Steps = (SEQ_BITS + srb_pkg::ChunkBits - 1) / srb_pkg::ChunkBits;
  localparam int PadW  = Steps * srb_pkg::ChunkBits;
  localparam int CntW  = $clog2(Steps + 1);

  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic [CntW-1:0]         cnt_r, cnt_nxt;
  logic [PadW-1:0]         sh_r, sh_nxt;
  logic [SlotW-1:0]        rem_r, rem_nxt;
  logic [SlotW-1:0]        rem_step;
  logic [SEQ_BITS-1:0]     seq_r;
  logic [PAYLOAD_BITS-1:0] pay_r;
  logic                    rep_r;
  logic                    accept;

  assign full   = busy_r;
  assign accept = push && !busy_r;

  // Fold the top chunk into the residue, one restoring step per bit.
  always_comb begin
    logic [SlotW:0]   t;
    logic [SlotW-1:0] r;
    r = rem_r;
    t = '0;
    for (int i = srb_pkg::ChunkBits - 1; i >= 0; i--) begin
      t = {r, sh_r[PadW - srb_pkg::ChunkBits + i]};
      if (t >= (SlotW+1)'(SLOT_COUNT)) begin
        t = t - (SlotW+1)'(SLOT_COUNT);
      end
      r = t[SlotW-1:0];
    end
    rem_step = r;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    q_push   = 1'b0;
    if (accept) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = '0;
      sh_nxt   = PadW'(in_seq_num);
      rem_nxt  = '0;
    end else if (busy_r && !done_r) begin
      rem_nxt = rem_step;
      sh_nxt  = sh_r << srb_pkg::ChunkBits;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CntW'(Steps - 1)) begin
        done_nxt = 1'b1;
      end
    end else if (busy_r && done_r && !q_status.full) begin
      q_push   = 1'b1;
      busy_nxt = 1'b0;
      done_nxt = 1'b0;
    end
  end

  assign q_wdata = {seq_r, pay_r, rep_r, rem_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
    if (accept) begin
      seq_r <= in_seq_num;
      pay_r <= in_payload;
      rep_r <= in_repeat_flag;
    end
  end

endmodule

### rtl/srb_queue.sv
// srb_queue: short register queue that decouples the front from the back.
// Depends on srb_pkg.
module srb_queue #(
  parameter int WIDTH = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic [WIDTH-1:0]   wdata,
  input  logic               pop,
  output logic [WIDTH-1:0]   rdata,
  output srb_pkg::q_status_t status
);

  localparam int PtrW = $clog2(srb_pkg::QDepth);
  localparam int CntW = $clog2(srb_pkg::QDepth + 1);

  logic [WIDTH-1:0] data_r [srb_pkg::QDepth];
  logic [PtrW-1:0]  wptr_r, wptr_nxt;
  logic [PtrW-1:0]  rptr_r, rptr_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign status.full  = (cnt_r == CntW'(srb_pkg::QDepth));
  assign status.empty = (cnt_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign rdata        = data_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PtrW'(srb_pkg::QDepth - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PtrW'(srb_pkg::QDepth - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
    if (do_push) begin
      data_r[wptr_r] <= wdata;
    end
  end

endmodule

### rtl/srb_back.sv
// srb_back: slot store, occupancy check and in-order release into the output
// register. Depends on srb_pkg and srb_ram.
module srb_back #(
  parameter int SLOT_COUNT   = 8,
  parameter int SEQ_BITS     = 16,
  parameter int PAYLOAD_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  srb_pkg::q_status_t                     q_status,
  input  logic [SEQ_BITS+PAYLOAD_BITS+$clog2(SLOT_COUNT):0] q_rdata,
  output logic                                   q_pop,
  output logic                                   empty,
  input  logic                                   pop,
  output logic [PAYLOAD_BITS-1:0]                out_payload,
  output logic [SEQ_BITS-1:0]                    out_seq,
  output logic                                   out_error_flag,
  output logic                                   out_last_flag
);

  localparam int SlotW = $clog2(SLOT_COUNT);
  localparam int EntW  = SEQ_BITS + PAYLOAD_BITS + 1;

  typedef enum logic [3:0] {
    S_CHECK = 4'b0001,
    S_LOOK  = 4'b0010,
    S_READ  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [SLOT_COUNT-1:0]   occ_r, occ_nxt;
  logic [SEQ_BITS-1:0]     exp_r, exp_nxt;
  logic [SlotW-1:0]        eslot_r, eslot_nxt;
  logic                    second_r, second_nxt;

  logic [SEQ_BITS-1:0]     h_seq;
  logic [PAYLOAD_BITS-1:0] h_pay;
  logic                    h_rep;
  logic [SlotW-1:0]        h_slot;

  logic                    ram_we, ram_re;
  logic [EntW-1:0]         ram_rdata;
  logic [SEQ_BITS-1:0]     rd_seq;
  logic [PAYLOAD_BITS-1:0] rd_pay;
  logic                    rd_rep;

  logic [SEQ_BITS-1:0]     exp_inc;
  logic [SlotW-1:0]        slot_inc;
  logic                    occ_after;

  logic                    out_valid_r;
  logic                    out_free, out_load;
  logic [PAYLOAD_BITS-1:0] ld_pay, out_pay_r;
  logic [SEQ_BITS-1:0]     ld_seq, out_seq_r;
  logic                    ld_err, out_err_r;
  logic                    ld_last, out_last_r;

  assign {h_seq, h_pay, h_rep, h_slot} = q_rdata;
  assign {rd_seq, rd_pay, rd_rep}      = ram_rdata;

  srb_ram #(
    .WIDTH (EntW),
    .DEPTH (SLOT_COUNT)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (h_slot),
    .wdata ({h_seq, h_pay, h_rep}),
    .re    (ram_re),
    .raddr (eslot_r),
    .rdata (ram_rdata)
  );

  // Next expected slot; restart at slot zero when the sequence wraps.
  assign exp_inc  = exp_r + 1'b1;
  assign slot_inc = (exp_inc == '0) ? '0 :
                    (eslot_r == SlotW'(SLOT_COUNT - 1)) ? '0 : eslot_r + 1'b1;
  assign occ_after = (slot_inc == eslot_r) ? 1'b0 : occ_r[slot_inc];

  assign out_free = !out_valid_r || pop;

  always_comb begin
    state_nxt  = state_r;
    occ_nxt    = occ_r;
    exp_nxt    = exp_r;
    eslot_nxt  = eslot_r;
    second_nxt = second_r;
    q_pop      = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    out_load   = 1'b0;
    ld_pay     = h_pay;
    ld_seq     = h_seq;
    ld_err     = 1'b0;
    ld_last    = 1'b0;
    case (state_r)
      S_CHECK: begin
        if (!q_status.empty) begin
          if (occ_r[h_slot]) begin
            if (out_free) begin
              out_load = 1'b1;
              ld_err   = 1'b1;
              ld_last  = 1'b1;
              q_pop    = 1'b1;
            end
          end else begin
            ram_we          = 1'b1;
            occ_nxt[h_slot] = 1'b1;
            q_pop           = 1'b1;
            state_nxt       = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        if (occ_r[eslot_r]) begin
          ram_re    = 1'b1;
          state_nxt = S_READ;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_READ: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          ld_pay   = rd_pay;
          ld_seq   = rd_seq;
          if (rd_rep && !second_r) begin
            second_nxt = 1'b1;
          end else begin
            ld_last          = !occ_after;
            second_nxt       = 1'b0;
            occ_nxt[eslot_r] = 1'b0;
            exp_nxt          = exp_inc;
            eslot_nxt        = slot_inc;
            state_nxt        = S_LOOK;
          end
        end
      end
      default: begin
        state_nxt = S_CHECK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CHECK;
      occ_r       <= '0;
      exp_r       <= '0;
      eslot_r     <= '0;
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      occ_r    <= occ_nxt;
      exp_r    <= exp_nxt;
      eslot_r  <= eslot_nxt;
      second_r <= second_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
    if (out_load) begin
      out_pay_r  <= ld_pay;
      out_seq_r  <= ld_seq;
      out_err_r  <= ld_err;
      out_last_r <= ld_last;
    end
  end

  assign empty          = !out_valid_r;
  assign out_payload    = out_pay_r;
  assign out_seq        = out_seq_r;
  assign out_error_flag = out_err_r;
  assign out_last_flag  = out_last_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || pop))
    else $error("output word overwritten before it was taken");

  a_emit_occupied: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> occ_r[eslot_r])
    else $error("release from an empty slot");

  a_read_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |=> (state_r == S_EMIT))
    else $error("slot read not followed by release");

  a_store_marks: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> (occ_r[$past(h_slot)] && (state_r == S_LOOK)))
    else $error("stored slot not marked occupied");

endmodule
